// ===== sv/assert_macros.svh =====
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NTA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// antecedent implies consequent in the next cycle
`define NTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== sv/nta_pkg.sv =====
// shared types and constants of the neighbor table and rank block
package nta_pkg;

	localparam int DEF_TABLE_DEPTH = 32;
	localparam int ID_W            = 64;
	localparam int STRENGTH_W      = 8;
	localparam int TIME_W          = 32;

	localparam logic CMD_BEACON = 1'b0;
	localparam logic CMD_ASSIGN = 1'b1;

	typedef enum logic [2:0] {
		ST_INVALID  = 3'd0,
		ST_SELF     = 3'd1,
		ST_UPDATED  = 3'd2,
		ST_ADDED    = 3'd3,
		ST_FULL     = 3'd4,
		ST_ASSIGNED = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		CFG_OWN_ID        = 3'd0,
		CFG_HIGHEST_FIRST = 3'd1,
		CFG_MAGIC_FIRST   = 3'd2,
		CFG_MAGIC_SECOND  = 3'd3,
		CFG_MIN_LENGTH    = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_FINISH
	} state_t;

	// values seen by every cell during a sweep
	typedef struct packed {
		logic                  cmd;
		logic                  highest_first;
		logic [ID_W-1:0]       key;
		logic [STRENGTH_W-1:0] strength;
		logic [TIME_W-1:0]     now;
	} bcast_t;

	// token passed from cell to cell
	typedef struct packed {
		logic valid;
		logic found;
		logic added;
	} tok_t;

endpackage

// ===== sv/neighbor_table_rank_assign.sv =====
// top level: neighbor table as a chain of entry cells with rank assignment
// A beacon that is too short, carries a wrong magic or our own ID is answered
// in the cycle after it is taken and leaves the table alone. Every other beacon
// and every assign word runs a token down the chain of TABLE_DEPTH entry cells,
// one cell a cycle; the result is then registered and waits in the finish state
// until the output register is free. One word is in the chain at a time, and a
// new word is taken only once the output register is empty or being read in the
// same cycle.
// Configuration writes are always taken and should come only while idle.
module neighbor_table_rank_assign
	import nta_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         cmd,
	input  logic [7:0]                   beacon_length,
	input  logic [7:0]                   magic_first_in,
	input  logic [7:0]                   magic_second_in,
	input  logic [ID_W-1:0]              sender_id,
	input  logic signed [STRENGTH_W-1:0] signal_strength,
	input  logic [TIME_W-1:0]            now_ms,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   status,
	output logic [5:0]                   logical_rank,
	output logic                         coordinator,
	output logic [5:0]                   node_total,
	output logic [6:0]                   generation_size,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [2:0]                   cfg_index,
	input  logic [63:0]                  cfg_data
);

	localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
	localparam int WIDE_W = CNT_W + 8;

	state_t state_q, state_d;

	logic [ID_W-1:0] own_id_q;
	logic            hf_q;
	logic [7:0]      magic_first_q;
	logic [7:0]      magic_second_q;
	logic [7:0]      min_len_q;

	logic [CNT_W-1:0] count_q;

	logic                  cmd_q;
	logic [ID_W-1:0]       key_q;
	logic [STRENGTH_W-1:0] strength_q;
	logic [TIME_W-1:0]     now_q;
	logic                  start_q;
	bcast_t                bc;

	tok_t             tok  [0:TABLE_DEPTH];
	logic [CNT_W-1:0] rank [0:TABLE_DEPTH];

	tok_t             fin_tok_q;
	logic [CNT_W-1:0] fin_rank_q;

	logic        out_valid_q;
	status_t     status_q;
	logic [5:0]  rank_out_q;
	logic        coord_q;
	logic [5:0]  total_q;
	logic [6:0]  gen_q;

	logic accept;
	logic out_free;
	logic bad_beacon;
	logic self_beacon;
	logic drop;
	logic finish_go;

	logic [WIDE_W-1:0] total_w;
	logic [WIDE_W-1:0] gen_w;
	logic [WIDE_W-1:0] rank_w;

	// config port
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q       <= '0;
			hf_q           <= 1'b0;
			magic_first_q  <= '0;
			magic_second_q <= '0;
			min_len_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_OWN_ID:        own_id_q       <= cfg_data;
				CFG_HIGHEST_FIRST: hf_q           <= cfg_data[0];
				CFG_MAGIC_FIRST:   magic_first_q  <= cfg_data[7:0];
				CFG_MAGIC_SECOND:  magic_second_q <= cfg_data[7:0];
				CFG_MIN_LENGTH:    min_len_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// input checks
	always_comb begin
		out_free    = !out_valid_q || out_ready;
		bad_beacon  = (beacon_length < min_len_q) || (magic_first_in != magic_first_q)
			|| (magic_second_in != magic_second_q);
		self_beacon = sender_id == own_id_q;
		drop        = (cmd == CMD_BEACON) && (bad_beacon || self_beacon);
		accept      = in_valid && in_ready;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !drop) state_d = S_SWEEP;
			end
			S_SWEEP: begin
				if (tok[TABLE_DEPTH].valid) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_ready  = 1'b0;
		finish_go = 1'b0;
		unique case (state_q)
			S_IDLE:   in_ready  = out_free;
			S_SWEEP:  ;
			S_FINISH: finish_go = out_free;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && !drop;
		end
	end

	// broadcast word held for the sweep
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			key_q      <= (cmd == CMD_ASSIGN) ? own_id_q : sender_id;
			strength_q <= signal_strength;
			now_q      <= now_ms;
		end
	end

	always_comb begin
		bc.cmd           = cmd_q;
		bc.highest_first = hf_q;
		bc.key           = key_q;
		bc.strength      = strength_q;
		bc.now           = now_q;
	end

	// cell chain
	always_comb begin
		tok[0].valid = start_q;
		tok[0].found = 1'b0;
		tok[0].added = 1'b0;
		rank[0]      = '0;
	end

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		nta_cell #(
			.CNT_W (CNT_W),
			.IDX   (g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.bc       (bc),
			.count    (count_q),
			.tok_in   (tok[g]),
			.rank_in  (rank[g]),
			.tok_out  (tok[g+1]),
			.rank_out (rank[g+1])
		);
	end

	always_ff @(posedge clk) begin
		if (tok[TABLE_DEPTH].valid) begin
			fin_tok_q  <= tok[TABLE_DEPTH];
			fin_rank_q <= rank[TABLE_DEPTH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (finish_go && (cmd_q == CMD_BEACON) && fin_tok_q.added) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// result word
	always_comb begin
		total_w = WIDE_W'(count_q) + WIDE_W'(1);
		gen_w   = total_w << 1;
		rank_w  = WIDE_W'(fin_rank_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && drop) || finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && drop) begin
			status_q   <= bad_beacon ? ST_INVALID : ST_SELF;
			rank_out_q <= '0;
			coord_q    <= 1'b0;
			total_q    <= '0;
			gen_q      <= '0;
		end else if (finish_go) begin
			if (cmd_q == CMD_ASSIGN) begin
				status_q   <= ST_ASSIGNED;
				rank_out_q <= rank_w[5:0];
				coord_q    <= fin_rank_q == '0;
				total_q    <= total_w[5:0];
				gen_q      <= gen_w[6:0];
			end else begin
				priority if (fin_tok_q.found) begin
					status_q <= ST_UPDATED;
				end else if (fin_tok_q.added) begin
					status_q <= ST_ADDED;
				end else begin
					status_q <= ST_FULL;
				end
				rank_out_q <= '0;
				coord_q    <= 1'b0;
				total_q    <= '0;
				gen_q      <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign logical_rank    = rank_out_q;
	assign coordinator     = coord_q;
	assign node_total      = total_q;
	assign generation_size = gen_q;

endmodule

// ===== sv/nta_cell.sv =====
// one table entry: id, strength and last-seen time, with its compare step
module nta_cell
	import nta_pkg::*;
#(
	parameter int CNT_W = 6,
	parameter int IDX   = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  bcast_t           bc,
	input  logic [CNT_W-1:0] count,
	input  tok_t             tok_in,
	input  logic [CNT_W-1:0] rank_in,
	output tok_t             tok_out,
	output logic [CNT_W-1:0] rank_out
);

	logic [ID_W-1:0]       id_q;
	logic [STRENGTH_W-1:0] strength_q;
	logic [TIME_W-1:0]     last_seen_q;
	tok_t                  tok_q;
	logic [CNT_W-1:0]      rank_q;

	logic live;
	logic hit;
	logic app;
	logic ahead;

	always_comb begin
		live  = count > CNT_W'(IDX);
		hit   = tok_in.valid && (bc.cmd == CMD_BEACON) && live && !tok_in.found
			&& (id_q == bc.key);
		app   = tok_in.valid && (bc.cmd == CMD_BEACON) && !tok_in.found
			&& (count == CNT_W'(IDX));
		ahead = tok_in.valid && (bc.cmd == CMD_ASSIGN) && live
			&& (bc.highest_first ? (id_q > bc.key) : (id_q < bc.key));
	end

	always_ff @(posedge clk) begin
		if (app) begin
			id_q <= bc.key;
		end
		if (app || hit) begin
			strength_q  <= bc.strength;
			last_seen_q <= bc.now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found | hit;
			tok_q.added <= tok_in.added | app;
		end
	end

	always_ff @(posedge clk) begin
		rank_q <= rank_in + CNT_W'(ahead);
	end

	assign tok_out  = tok_q;
	assign rank_out = rank_q;

endmodule

// ===== sv/nta_checker.sv =====
// port-level checks of the neighbor table block, bound to the top level
`include "assert_macros.svh"

module nta_checker
	import nta_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] status,
	input logic [5:0] logical_rank,
	input logic       coordinator,
	input logic [5:0] node_total,
	input logic [6:0] generation_size
);

	logic assigned;
	logic fields_zero;
	assign assigned    = out_valid && (status == ST_ASSIGNED);
	assign fields_zero = node_total == 6'd0 && generation_size == 7'd0 && !coordinator;

	`NTA_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status))
	`NTA_ASSERT_IMPLY(a_gen_twice, clk, arst_n, assigned, generation_size == {node_total, 1'b0})
	`NTA_ASSERT_IMPLY(a_coord_rank, clk, arst_n, assigned && coordinator, logical_rank == 6'd0)
	`NTA_ASSERT_IMPLY(a_beacon_zero, clk, arst_n, out_valid && !assigned, fields_zero)

endmodule

bind neighbor_table_rank_assign nta_checker u_nta_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.logical_rank    (logical_rank),
	.coordinator     (coordinator),
	.node_total      (node_total),
	.generation_size (generation_size)
);

// ===== bench/neighbor_table_rank_assign_tb.sv =====
// testbench for the neighbor table and rank block: directed table, random phases, predictor
`timescale 1ns / 1ps

module neighbor_table_rank_assign_tb;
	import nta_pkg::*;

	localparam int DEPTH       = DEF_TABLE_DEPTH;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 105;
	localparam int QUIET_LIMIT = 2000;
	localparam int PRINT_CAP   = 50;

	typedef struct packed {
		logic                  cmd;
		logic [7:0]            len;
		logic [7:0]            m0;
		logic [7:0]            m1;
		logic [ID_W-1:0]       sid;
		logic signed [7:0]     ss;
		logic [TIME_W-1:0]     now;
	} word_t;

	typedef struct packed {
		status_t    st;
		logic [5:0] rank;
		logic       coord;
		logic [5:0] total;
		logic [6:0] gen;
	} answer_t;

	typedef struct packed {
		word_t   w;
		logic    typed;
		answer_t ans;
	} row_t;

	localparam logic [63:0] DIR_OWN = 64'h5A5A_0000_1234_5678;
	localparam logic [63:0] ID_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [7:0]  MA      = 8'hC3;
	localparam logic [7:0]  MB      = 8'h3C;
	localparam logic [7:0]  ML      = 8'd24;

	localparam answer_t A_INVALID = '{ST_INVALID, 6'd0, 1'b0, 6'd0, 7'd0};
	localparam answer_t A_SELF    = '{ST_SELF, 6'd0, 1'b0, 6'd0, 7'd0};
	localparam answer_t A_UPDATED = '{ST_UPDATED, 6'd0, 1'b0, 6'd0, 7'd0};
	localparam answer_t A_ADDED   = '{ST_ADDED, 6'd0, 1'b0, 6'd0, 7'd0};

	// first rows run under reset register values
	localparam int RESET_ROWS = 2;
	localparam int DIR_ROWS   = 22;
	// cmd, len, magic first, magic second, sender, strength, time; typed; answer
	localparam row_t DIRECTED [DIR_ROWS] = '{
		'{'{CMD_ASSIGN, 8'd0, 8'd0, 8'd0, 64'd0, 8'h00, 32'd0}, 1'b1,
			'{ST_ASSIGNED, 6'd0, 1'b1, 6'd1, 7'd2}},
		'{'{CMD_BEACON, 8'd0, 8'd0, 8'd0, 64'd0, 8'h00, 32'd0}, 1'b1, A_SELF},
		'{'{CMD_BEACON, 8'd23, MA, MB, 64'd5, 8'h10, 32'd7}, 1'b1, A_INVALID},
		'{'{CMD_BEACON, 8'd0, MA, MB, 64'd1, 8'h10, 32'd7}, 1'b1, A_INVALID},
		'{'{CMD_BEACON, 8'd255, MA ^ 8'h01, MB, 64'd5, 8'h10, 32'd7}, 1'b1, A_INVALID},
		'{'{CMD_BEACON, 8'd24, MA, MB ^ 8'h80, 64'd5, 8'h10, 32'd7}, 1'b1, A_INVALID},
		'{'{CMD_BEACON, 8'd24, ~MA, ~MB, 64'd5, 8'h10, 32'd7}, 1'b1, A_INVALID},
		'{'{CMD_BEACON, 8'd23, MA, MB, DIR_OWN, 8'h10, 32'd7}, 1'b1, A_INVALID},
		'{'{CMD_BEACON, 8'd24, MA, MB, DIR_OWN, 8'h80, 32'd0}, 1'b1, A_SELF},
		'{'{CMD_BEACON, 8'd255, MA, MB, DIR_OWN, 8'h7F, 32'hFFFF_FFFF}, 1'b1, A_SELF},
		'{'{CMD_BEACON, 8'd24, MA, MB, 64'd0, 8'h80, 32'd0}, 1'b1, A_ADDED},
		'{'{CMD_BEACON, 8'd255, MA, MB, ID_MAX, 8'h7F, 32'hFFFF_FFFF}, 1'b1, A_ADDED},
		'{'{CMD_BEACON, 8'd30, MA, MB, 64'd0, 8'h00, 32'd1000}, 1'b1, A_UPDATED},
		'{'{CMD_BEACON, 8'd24, MA, MB, 64'h5A5A_0000_1234_5677, 8'hC4, 32'd2000}, 1'b1,
			A_ADDED},
		'{'{CMD_BEACON, 8'd24, MA, MB, 64'h5A5A_0000_1234_5679, 8'hB0, 32'd3000}, 1'b1,
			A_ADDED},
		'{'{CMD_ASSIGN, 8'd0, 8'd0, 8'd0, 64'd0, 8'h00, 32'd0}, 1'b1,
			'{ST_ASSIGNED, 6'd2, 1'b0, 6'd5, 7'd10}},
		'{'{CMD_BEACON, 8'd40, MA, MB, 64'h5A5A_0000_1234_5679, 8'hD0, 32'd4000}, 1'b1,
			A_UPDATED},
		'{'{CMD_BEACON, 8'd40, MA, 8'h00, 64'h5A5A_0000_1234_5679, 8'hD0, 32'd4000}, 1'b1,
			A_INVALID},
		'{'{CMD_BEACON, 8'd99, MA, MB, 64'h8000_0000_0000_0000, 8'hE2, 32'd5000}, 1'b0,
			A_INVALID},
		'{'{CMD_ASSIGN, 8'hFF, 8'hFF, 8'hFF, ID_MAX, 8'hFF, 32'hFFFF_FFFF}, 1'b0, A_INVALID},
		'{'{CMD_BEACON, 8'd24, MA, MB, 64'd1, 8'h80, 32'd6000}, 1'b0, A_INVALID},
		'{'{CMD_ASSIGN, 8'd0, 8'd0, 8'd0, 64'd0, 8'h00, 32'd0}, 1'b0, A_INVALID}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic              cmd;
	logic [7:0]        beacon_length;
	logic [7:0]        magic_first_in;
	logic [7:0]        magic_second_in;
	logic [ID_W-1:0]   sender_id;
	logic signed [7:0] signal_strength;
	logic [TIME_W-1:0] now_ms;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic [5:0]        logical_rank;
	logic              coordinator;
	logic [5:0]        node_total;
	logic [6:0]        generation_size;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [63:0]       cfg_data;

	// predictor state and register copies
	logic [63:0]       reg_own_id;
	logic              reg_highest_first;
	logic [7:0]        reg_magic_first;
	logic [7:0]        reg_magic_second;
	logic [7:0]        reg_min_length;
	logic [63:0]       known_ids [DEPTH];
	logic [7:0]        known_strength [DEPTH];
	logic [31:0]       known_seen [DEPTH];
	int                known_count;

	answer_t           answers_due [$];
	int                error_count;
	int                words_sent;
	int                settings_used;
	int                status_count [6];
	int                quiet_cycles;
	int                in_gap_pct;
	int                out_stall_pct;

	neighbor_table_rank_assign #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.beacon_length(beacon_length),
		.magic_first_in(magic_first_in),
		.magic_second_in(magic_second_in),
		.sender_id(sender_id),
		.signal_strength(signal_strength),
		.now_ms(now_ms),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.logical_rank(logical_rank),
		.coordinator(coordinator),
		.node_total(node_total),
		.generation_size(generation_size),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic flag_error(input string msg);
		if (error_count < PRINT_CAP) begin
			$display("ERROR %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	function automatic answer_t predict_answer(input word_t w);
		answer_t a;
		int      rank;
		logic    hit;
		a = '0;
		rank = 0;
		hit = 1'b0;
		if (w.cmd == CMD_ASSIGN) begin
			for (int i = 0; i < known_count; i++) begin
				if (reg_highest_first ? (known_ids[i] > reg_own_id) : (known_ids[i] < reg_own_id))
					rank++;
			end
			a.st = ST_ASSIGNED;
			a.rank = 6'(rank);
			a.coord = (rank == 0);
			a.total = 6'(known_count + 1);
			a.gen = 7'(2 * (known_count + 1));
		end else if (w.len < reg_min_length || w.m0 != reg_magic_first ||
				w.m1 != reg_magic_second) begin
			a.st = ST_INVALID;
		end else if (w.sid == reg_own_id) begin
			a.st = ST_SELF;
		end else begin
			for (int i = 0; i < known_count; i++) begin
				if (!hit && known_ids[i] == w.sid) begin
					known_strength[i] = w.ss;
					known_seen[i] = w.now;
					hit = 1'b1;
				end
			end
			if (hit) begin
				a.st = ST_UPDATED;
			end else if (known_count < DEPTH) begin
				known_ids[known_count] = w.sid;
				known_strength[known_count] = w.ss;
				known_seen[known_count] = w.now;
				known_count++;
				a.st = ST_ADDED;
			end else begin
				a.st = ST_FULL;
			end
		end
		return a;
	endfunction

	function automatic logic [63:0] known_pick();
		if (known_count == 0)
			return {$urandom, $urandom};
		return known_ids[$urandom_range(known_count - 1)];
	endfunction

	function automatic word_t random_word();
		word_t w;
		int    pick;
		int    idpick;
		w.cmd = CMD_BEACON;
		w.len = 8'($urandom);
		w.m0 = 8'($urandom);
		w.m1 = 8'($urandom);
		w.sid = {$urandom, $urandom};
		w.ss = 8'($urandom);
		w.now = $urandom;
		pick = $urandom_range(99);
		if (pick < 20) begin
			w.cmd = CMD_ASSIGN;
		end else if (pick < 28) begin
			// too short
			w.m0 = reg_magic_first;
			w.m1 = reg_magic_second;
			if (reg_min_length != 0)
				w.len = 8'($urandom_range(reg_min_length - 1));
		end else if (pick < 36) begin
			// one bad magic byte
			w.len = 8'($urandom_range(255, reg_min_length));
			w.m0 = reg_magic_first;
			w.m1 = reg_magic_second;
			if ($urandom_range(1))
				w.m0 = w.m0 ^ 8'($urandom_range(255, 1));
			else
				w.m1 = w.m1 ^ 8'($urandom_range(255, 1));
		end else begin
			w.len = 8'($urandom_range(255, reg_min_length));
			w.m0 = reg_magic_first;
			w.m1 = reg_magic_second;
			idpick = $urandom_range(99);
			if (idpick < 15) begin
				w.sid = reg_own_id;
			end else if (idpick < 60 && known_count != 0) begin
				w.sid = known_pick();
			end else if (idpick < 70) begin
				case ($urandom_range(3))
					0: w.sid = '0;
					1: w.sid = ID_MAX;
					2: w.sid = reg_own_id + 64'd1;
					default: w.sid = reg_own_id - 64'd1;
				endcase
			end
		end
		return w;
	endfunction

	task automatic send_word(input word_t w, input logic typed, input answer_t typed_ans);
		answer_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= w.cmd;
		beacon_length <= w.len;
		magic_first_in <= w.m0;
		magic_second_in <= w.m1;
		sender_id <= w.sid;
		signal_strength <= w.ss;
		now_ms <= w.now;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predicted = predict_answer(w);
		answers_due.push_back(typed ? typed_ans : predicted);
		words_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_OWN_ID:        reg_own_id = data;
			CFG_HIGHEST_FIRST: reg_highest_first = data[0];
			CFG_MAGIC_FIRST:   reg_magic_first = data[7:0];
			CFG_MAGIC_SECOND:  reg_magic_second = data[7:0];
			CFG_MIN_LENGTH:    reg_min_length = data[7:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [63:0] own, input logic hf, input logic [7:0] m0,
			input logic [7:0] m1, input logic [7:0] min_len);
		write_reg(CFG_OWN_ID, own);
		write_reg(CFG_HIGHEST_FIRST, {63'd0, hf});
		write_reg(CFG_MAGIC_FIRST, {56'd0, m0});
		write_reg(CFG_MAGIC_SECOND, {56'd0, m1});
		write_reg(CFG_MIN_LENGTH, {56'd0, min_len});
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// receiver side
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (answers_due.size() == 0) begin
				flag_error($sformatf("result word with no expectation, status %0d", status));
			end else begin
				want = answers_due.pop_front();
				if (status !== want.st)
					flag_error($sformatf("status got %0d want %0d", status, want.st));
				if (logical_rank !== want.rank)
					flag_error($sformatf("logical_rank got %0d want %0d", logical_rank,
						want.rank));
				if (coordinator !== want.coord)
					flag_error($sformatf("coordinator got %0d want %0d", coordinator,
						want.coord));
				if (node_total !== want.total)
					flag_error($sformatf("node_total got %0d want %0d", node_total,
						want.total));
				if (generation_size !== want.gen)
					flag_error($sformatf("generation_size got %0d want %0d", generation_size,
						want.gen));
			end
			if (status <= ST_ASSIGNED)
				status_count[status]++;
		end
	end

	// watchdog on handshake activity
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("no handshake for %0d cycles", quiet_cycles);
			$display("neighbor_table_rank_assign verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_BEACON;
		beacon_length = '0;
		magic_first_in = '0;
		magic_second_in = '0;
		sender_id = '0;
		signal_strength = '0;
		now_ms = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_OWN_ID;
		cfg_data = '0;
		reg_own_id = '0;
		reg_highest_first = 1'b0;
		reg_magic_first = '0;
		reg_magic_second = '0;
		reg_min_length = '0;
		known_count = 0;
		error_count = 0;
		words_sent = 0;
		settings_used = 1;
		quiet_cycles = 0;
		in_gap_pct = 0;
		out_stall_pct = 0;
		foreach (status_count[i])
			status_count[i] = 0;
		for (int i = 0; i < DEPTH; i++) begin
			known_ids[i] = '0;
			known_strength[i] = '0;
			known_seen[i] = '0;
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			if (r == RESET_ROWS) begin
				drain();
				program_regs(DIR_OWN, 1'b0, MA, MB, ML);
			end
			send_word(DIRECTED[r].w, DIRECTED[r].typed, DIRECTED[r].ans);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: program_regs({$urandom, $urandom}, 1'b0, 8'($urandom), 8'($urandom),
					8'($urandom_range(40)));
				1: program_regs('0, 1'b0, 8'h00, 8'h00, 8'd0);
				2: program_regs(ID_MAX, 1'b1, 8'hFF, 8'hFF, 8'd255);
				3: program_regs(known_pick(), 1'b1, 8'($urandom), 8'($urandom),
					8'($urandom_range(60)));
				4: program_regs(known_pick(), 1'b0, 8'($urandom), 8'($urandom),
					8'($urandom_range(60)));
				5: program_regs(ID_MAX, 1'b0, 8'hA5, 8'h5A, 8'd1);
				6: program_regs('0, 1'b1, 8'($urandom), 8'($urandom), 8'($urandom_range(255)));
				default: program_regs({$urandom, $urandom}, 1'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom_range(80)));
			endcase
			case (p % 4)
				0: begin
					in_gap_pct = 0;
					out_stall_pct = 0;
				end
				1: begin
					in_gap_pct = 54;
					out_stall_pct = 0;
				end
				2: begin
					in_gap_pct = 0;
					out_stall_pct = 54;
				end
				default: begin
					in_gap_pct = 18;
					out_stall_pct = 18;
				end
			endcase
			repeat (PHASE_WORDS)
				send_word(random_word(), 1'b0, A_INVALID);
			drain();
		end

		repeat (DEPTH + 8) @(posedge clk);
		if (answers_due.size() != 0)
			flag_error($sformatf("%0d expected results never arrived", answers_due.size()));
		$display("ran %0d words under %0d register settings, table ended with %0d of %0d entries",
			words_sent, settings_used, known_count, DEPTH);
		$display("results: dropped %0d, own id %0d, updated %0d, added %0d, full %0d, ranked %0d",
			status_count[ST_INVALID], status_count[ST_SELF], status_count[ST_UPDATED],
			status_count[ST_ADDED], status_count[ST_FULL], status_count[ST_ASSIGNED]);
		if (error_count == 0) begin
			$display("neighbor_table_rank_assign verification clean");
		end else begin
			$display("neighbor_table_rank_assign verification failed");
		end
		$finish;
	end

endmodule
